[sv/detection_track_table_macros.svh]
// Assertion macros shared by the detection track table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef DETECTION_TRACK_TABLE_MACROS_SVH
`define DETECTION_TRACK_TABLE_MACROS_SVH

// Property checked on every rising clock edge, skipped during reset
`define DTT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included
`define DTT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/dtt_pkg.sv]
// Package for the detection track table: sizes, codes, sequencer states.
// No dependencies; imported by dtt_div, detection_track_table and the testbench.
package dtt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // divider sizes
   localparam int DIV_NUM_W = 34;
   localparam int DIV_DEN_W = 23;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // request kinds
   localparam logic [1:0] KIND_DETECT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   // response status codes
   localparam logic [2:0] STATUS_UPDATED = 3'd0;
   localparam logic [2:0] STATUS_ADDED   = 3'd1;
   localparam logic [2:0] STATUS_DROPPED = 3'd2;
   localparam logic [2:0] STATUS_REMOVED = 3'd3;
   localparam logic [2:0] STATUS_TICKED  = 3'd4;
   localparam logic [2:0] STATUS_CLEARED = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_MATCH_RADIUS = 3'd0;
   localparam logic [2:0] CSR_MAX_AGE      = 3'd1;
   localparam logic [2:0] CSR_FRAME_AREA   = 3'd2;
   localparam logic [2:0] CSR_STAT_LO      = 3'd3;
   localparam logic [2:0] CSR_STAT_HI      = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RADIUS,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CMP,
      ST_EVICT,
      ST_PICK,
      ST_MUL_WH,
      ST_DEPTH_GO,
      ST_DEPTH_WAIT,
      ST_MUL_AVG,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

endpackage

[sv/dtt_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on dtt_pkg for widths and the request struct.
module dtt_div
   import dtt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_req_type          req,
   output logic                 busy,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot
);

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_NUM_W-1:0] quot_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 take;

   // one trial subtract per step
   assign trial = {rem_ff, quot_ff[DIV_NUM_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            cnt_ff <= DIV_CNT_W'(DIV_NUM_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= '0;
         den_ff  <= req.den;
         quot_ff <= req.num;
      end else if (cnt_ff != '0) begin
         if (take) begin
            rem_ff <= DIV_DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= trial[DIV_DEN_W-1:0];
         end
         quot_ff <= {quot_ff[DIV_NUM_W-2:0], take};
      end
   end

   assign busy = cnt_ff != '0;
   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[sv/detection_track_table.sv]
// Detection track table top level: sequencer, entry storage, shared multiplier.
// Depends on dtt_pkg, dtt_div and detection_track_table_macros.svh.
//
// Usage:
//   Requests come in on req_* (valid/ready); one response per request goes out
//   on rsp_* (valid/ready). Registers are to be written on csr_* only while the
//   block is idle; the block itself does not enforce this. csr_ready is always
//   high, unknown indexes are ignored. A detection is compared against the 16
//   entries one at a time through one shared 16x16 multiplier, in three steps
//   per entry (x square, y square, compare). A full table adds an eviction
//   sweep over all entries. The depth estimate, and for an update also the
//   running average, go through the shared bit-serial divider. A remove scans
//   every entry; a tick or a clear answers in the cycle after acceptance.
//   One request is handled at a time: req_ready is high only when the
//   sequencer is idle and the response register is empty. A stalled response
//   holds until rsp_ready; no new request is taken meanwhile.
//   Reset empties the table, zeroes the seconds clock and loads the register
//   defaults; there is no clearing pass.
`include "detection_track_table_macros.svh"

module detection_track_table
   import dtt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [6:0]  req_class_id,
   input  logic [10:0] req_pos_x,
   input  logic [10:0] req_pos_y,
   input  logic [10:0] req_box_w,
   input  logic [10:0] req_box_h,
   input  logic [7:0]  req_confidence,
   input  logic        req_stationary_hint,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [15:0] rsp_seen_count,
   output logic [7:0]  rsp_avg_confidence,
   output logic [7:0]  rsp_depth,
   output logic        rsp_stationary,
   output logic [4:0]  rsp_removed_count,
   output logic [4:0]  rsp_entry_count,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

   // registers
   logic [10:0] match_radius_ff;
   logic [15:0] max_age_ff;
   logic [22:0] area_px_ff;
   logic [63:0] stat_lo_ff;
   logic [63:0] stat_hi_ff;

   // entry storage
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [6:0]  ent_class_ff [TABLE_ENTRIES];
   logic [10:0] ent_x_ff     [TABLE_ENTRIES];
   logic [10:0] ent_y_ff     [TABLE_ENTRIES];
   logic [7:0]  ent_depth_ff [TABLE_ENTRIES];
   logic        ent_stat_ff  [TABLE_ENTRIES];
   logic [31:0] ent_last_ff  [TABLE_ENTRIES];
   logic [15:0] ent_count_ff [TABLE_ENTRIES];
   logic [7:0]  ent_avg_ff   [TABLE_ENTRIES];
   logic [31:0] now_ff;
   logic [CNT_W-1:0] cnt_ff;

   // latched request
   logic [1:0]  kind_ff;
   logic [6:0]  cls_ff;
   logic [10:0] x_ff;
   logic [10:0] y_ff;
   logic [10:0] w_ff;
   logic [10:0] h_ff;
   logic [7:0]  conf_ff;
   logic        hint_ff;

   // sequencer datapath
   state_type state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff;
   logic              add_ff;
   logic [CNT_W-1:0]  removed_ff;
   logic [31:0]       prod_ff;
   logic [21:0]       rr_ff;
   logic [21:0]       sqx_ff;
   logic [7:0]        depth_ff;
   logic [7:0]        avg_new_ff;

   // response register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [3:0]  rsp_slot_ff;
   logic [15:0] rsp_seen_ff;
   logic [7:0]  rsp_avg_ff;
   logic [7:0]  rsp_depth_ff;
   logic        rsp_stat_ff;
   logic [4:0]  rsp_removed_ff;
   logic [4:0]  rsp_entries_ff;

   // combinational
   logic        req_fire;
   logic        last;
   logic [10:0] adx;
   logic [10:0] ady;
   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [31:0] product;
   logic [22:0] dist_sq;
   logic        match;
   logic        aged;
   logic [15:0] n_new;
   logic [SLOT_W-1:0] free_slot;
   logic        free_found;
   logic        class_stat;
   logic [DIV_NUM_W-1:0] depth_num;
   logic [DIV_NUM_W-1:0] avg_num;
   div_req_type div_req;
   logic        div_busy;
   logic        div_done;
   logic [DIV_NUM_W-1:0] div_quot;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign last = idx_ff == LAST_SLOT;

   // entry read at the scan index
   assign adx = (ent_x_ff[idx_ff] >= x_ff) ? ent_x_ff[idx_ff] - x_ff : x_ff - ent_x_ff[idx_ff];
   assign ady = (ent_y_ff[idx_ff] >= y_ff) ? ent_y_ff[idx_ff] - y_ff : y_ff - ent_y_ff[idx_ff];
   assign dist_sq = {1'b0, sqx_ff} + {1'b0, prod_ff[21:0]};
   assign match = valid_ff[idx_ff] && (ent_class_ff[idx_ff] == cls_ff) &&
                  (dist_sq < {1'b0, rr_ff});
   assign aged = valid_ff[idx_ff] && ((now_ff - ent_last_ff[idx_ff]) >= {16'd0, max_age_ff});
   assign n_new = (ent_count_ff[idx_ff] == 16'hFFFF) ? 16'hFFFF : ent_count_ff[idx_ff] + 16'd1;
   assign class_stat = cls_ff[6] ? stat_hi_ff[cls_ff[5:0]] : stat_lo_ff[cls_ff[5:0]];

   // lowest free slot
   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot  = SLOT_W'(i);
            free_found = 1'b1;
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RADIUS: begin
            mul_a = {5'd0, match_radius_ff};
            mul_b = {5'd0, match_radius_ff};
         end
         ST_SQ_X: begin
            mul_a = {5'd0, adx};
            mul_b = {5'd0, adx};
         end
         ST_SQ_Y: begin
            mul_a = {5'd0, ady};
            mul_b = {5'd0, ady};
         end
         ST_MUL_WH: begin
            mul_a = {5'd0, w_ff};
            mul_b = {5'd0, h_ff};
         end
         ST_MUL_AVG: begin
            mul_a = {8'd0, ent_avg_ff[idx_ff]};
            mul_b = n_new - 16'd1;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign product = 32'(mul_a) * 32'(mul_b);

   // divider operands: w*h*2560 / area and the rounded running average
   assign depth_num = DIV_NUM_W'({prod_ff[21:0], 11'd0}) + DIV_NUM_W'({prod_ff[21:0], 9'd0});
   assign avg_num = DIV_NUM_W'(prod_ff[23:0]) + DIV_NUM_W'(conf_ff) + DIV_NUM_W'(n_new[15:1]);

   always_comb begin
      div_req.start = (state_ff == ST_DEPTH_GO) || (state_ff == ST_AVG_GO);
      if (state_ff == ST_DEPTH_GO) begin
         div_req.num = depth_num;
         div_req.den = (area_px_ff == '0) ? DIV_DEN_W'(1) : area_px_ff;
      end else begin
         div_req.num = avg_num;
         div_req.den = {7'd0, n_new};
      end
   end

   dtt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_DETECT || req_kind == KIND_REMOVE)) begin
               state_in = ST_RADIUS;
            end
         end
         ST_RADIUS: state_in = ST_SQ_X;
         ST_SQ_X:   state_in = ST_SQ_Y;
         ST_SQ_Y:   state_in = ST_CMP;
         ST_CMP: begin
            if (kind_ff == KIND_DETECT) begin
               if (match) begin
                  state_in = ST_MUL_WH;
               end else if (last) begin
                  state_in = (cnt_ff == CNT_W'(TABLE_ENTRIES)) ? ST_EVICT : ST_PICK;
               end else begin
                  state_in = ST_SQ_X;
               end
            end else begin
               state_in = last ? ST_IDLE : ST_SQ_X;
            end
         end
         ST_EVICT:      state_in = last ? ST_PICK : ST_EVICT;
         ST_PICK:       state_in = free_found ? ST_MUL_WH : ST_IDLE;
         ST_MUL_WH:     state_in = ST_DEPTH_GO;
         ST_DEPTH_GO:   state_in = ST_DEPTH_WAIT;
         ST_DEPTH_WAIT: begin
            if (div_done) begin
               state_in = add_ff ? ST_WRITE : ST_MUL_AVG;
            end
         end
         ST_MUL_AVG:  state_in = ST_AVG_GO;
         ST_AVG_GO:   state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: state_in = div_done ? ST_WRITE : ST_AVG_WAIT;
         ST_WRITE:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         match_radius_ff <= 11'd50;
         max_age_ff      <= 16'd60;
         area_px_ff      <= 23'd921600;
         stat_lo_ff      <= 64'd1657324662872358400;
         stat_hi_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MATCH_RADIUS: match_radius_ff <= csr_data[10:0];
            CSR_MAX_AGE:      max_age_ff      <= csr_data[15:0];
            CSR_FRAME_AREA:   area_px_ff      <= csr_data[22:0];
            CSR_STAT_LO:      stat_lo_ff      <= csr_data;
            CSR_STAT_HI:      stat_hi_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // control state: valid bits, counts, clock, response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cnt_ff       <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_kind == KIND_TICK) begin
                  now_ff       <= now_ff + 32'd1;
                  rsp_valid_ff <= 1'b1;
               end else if (req_fire && req_kind == KIND_CLEAR) begin
                  valid_ff     <= '0;
                  cnt_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_CMP: begin
               if (kind_ff == KIND_REMOVE) begin
                  if (match) begin
                     valid_ff[idx_ff] <= 1'b0;
                     cnt_ff           <= cnt_ff - CNT_W'(1);
                  end
                  if (last) begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_EVICT: begin
               if (aged) begin
                  valid_ff[idx_ff] <= 1'b0;
                  cnt_ff           <= cnt_ff - CNT_W'(1);
               end
            end
            ST_PICK: begin
               if (!free_found) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_WRITE: begin
               if (add_ff) begin
                  valid_ff[idx_ff] <= 1'b1;
                  cnt_ff           <= cnt_ff + CNT_W'(1);
               end
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // payload: request latch, scan datapath, entries, response fields
   always_ff @(posedge clock) begin
      prod_ff <= product;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_ff    <= req_kind;
               cls_ff     <= req_class_id;
               x_ff       <= req_pos_x;
               y_ff       <= req_pos_y;
               w_ff       <= req_box_w;
               h_ff       <= req_box_h;
               conf_ff    <= req_confidence;
               hint_ff    <= req_stationary_hint;
               idx_ff     <= '0;
               add_ff     <= 1'b0;
               removed_ff <= '0;
               rsp_status_ff  <= (req_kind == KIND_TICK) ? STATUS_TICKED : STATUS_CLEARED;
               rsp_slot_ff    <= '0;
               rsp_seen_ff    <= '0;
               rsp_avg_ff     <= '0;
               rsp_depth_ff   <= '0;
               rsp_stat_ff    <= 1'b0;
               rsp_removed_ff <= '0;
               rsp_entries_ff <= (req_kind == KIND_CLEAR) ? 5'd0 : 5'(cnt_ff);
            end
         end
         ST_SQ_X: begin
            if (idx_ff == '0) begin
               rr_ff <= prod_ff[21:0];
            end
         end
         ST_SQ_Y: sqx_ff <= prod_ff[21:0];
         ST_CMP: begin
            if (kind_ff == KIND_REMOVE) begin
               if (match) begin
                  removed_ff <= removed_ff + CNT_W'(1);
               end
               if (last) begin
                  rsp_status_ff  <= STATUS_REMOVED;
                  rsp_removed_ff <= 5'(removed_ff + (match ? CNT_W'(1) : CNT_W'(0)));
                  rsp_entries_ff <= 5'(cnt_ff - (match ? CNT_W'(1) : CNT_W'(0)));
               end else begin
                  idx_ff <= idx_ff + SLOT_W'(1);
               end
            end else if (!match) begin
               idx_ff <= last ? '0 : idx_ff + SLOT_W'(1);
            end
         end
         ST_EVICT: begin
            if (aged) begin
               removed_ff <= removed_ff + CNT_W'(1);
            end
            idx_ff <= idx_ff + SLOT_W'(1);
         end
         ST_PICK: begin
            idx_ff <= free_slot;
            add_ff <= 1'b1;
            if (!free_found) begin
               rsp_status_ff  <= STATUS_DROPPED;
               rsp_slot_ff    <= '0;
               rsp_seen_ff    <= '0;
               rsp_avg_ff     <= '0;
               rsp_depth_ff   <= '0;
               rsp_stat_ff    <= 1'b0;
               rsp_removed_ff <= '0;
               rsp_entries_ff <= 5'(cnt_ff);
            end
         end
         ST_DEPTH_WAIT: begin
            if (div_done) begin
               depth_ff <= (div_quot[DIV_NUM_W-1:8] != '0) ? 8'hFF : div_quot[7:0];
            end
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               avg_new_ff <= div_quot[7:0];
            end
         end
         ST_WRITE: begin
            ent_x_ff[idx_ff]     <= x_ff;
            ent_y_ff[idx_ff]     <= y_ff;
            ent_depth_ff[idx_ff] <= depth_ff;
            ent_last_ff[idx_ff]  <= now_ff;
            rsp_slot_ff          <= 4'(idx_ff);
            rsp_depth_ff         <= depth_ff;
            if (add_ff) begin
               ent_class_ff[idx_ff] <= cls_ff;
               ent_stat_ff[idx_ff]  <= hint_ff || class_stat;
               ent_count_ff[idx_ff] <= 16'd1;
               ent_avg_ff[idx_ff]   <= conf_ff;
               rsp_status_ff        <= STATUS_ADDED;
               rsp_seen_ff          <= 16'd1;
               rsp_avg_ff           <= conf_ff;
               rsp_stat_ff          <= hint_ff || class_stat;
               rsp_removed_ff       <= 5'(removed_ff);
               rsp_entries_ff       <= 5'(cnt_ff + CNT_W'(1));
            end else begin
               ent_stat_ff[idx_ff]  <= hint_ff;
               ent_count_ff[idx_ff] <= n_new;
               ent_avg_ff[idx_ff]   <= avg_new_ff;
               rsp_status_ff        <= STATUS_UPDATED;
               rsp_seen_ff          <= n_new;
               rsp_avg_ff           <= avg_new_ff;
               rsp_stat_ff          <= hint_ff;
               rsp_removed_ff       <= '0;
               rsp_entries_ff       <= 5'(cnt_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_seen_count     = rsp_seen_ff;
   assign rsp_avg_confidence = rsp_avg_ff;
   assign rsp_depth          = rsp_depth_ff;
   assign rsp_stationary     = rsp_stat_ff;
   assign rsp_removed_count  = rsp_removed_ff;
   assign rsp_entry_count    = rsp_entries_ff;

   // checks
   `DTT_ASSERT(a_count_tracks_valid, cnt_ff == CNT_W'($countones(valid_ff)), "entry count out of step with valid bits")
   `DTT_ASSERT(a_idle_div_quiet, (state_ff == ST_IDLE) |-> !div_busy, "divider busy while sequencer idle")
   `DTT_ASSERT(a_no_accept_pending, rsp_valid_ff |-> !req_ready, "request taken while response pending")
   `DTT_ASSERT_ALWAYS(a_div_start_idle, div_req.start |-> !div_busy, "divider restarted while busy")

endmodule

[tb/tb_detection_track_table.sv]
`timescale 1ns / 100ps
// Testbench for detection_track_table: a scoreboard class predicts each response
// from accepted requests; plain tasks drive requests and registers, an always block the stall pattern.
// Depends on dtt_pkg and the detection_track_table RTL.

module tb_detection_track_table
   import dtt_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;

   // one request as it was accepted
   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  class_id;
      logic [10:0] pos_x;
      logic [10:0] pos_y;
      logic [10:0] box_w;
      logic [10:0] box_h;
      logic [7:0]  confidence;
      logic        hint;
   } track_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [15:0] seen_count;
      logic [7:0]  avg_confidence;
      logic [7:0]  depth;
      logic        stationary;
      logic [4:0]  removed_count;
      logic [4:0]  entry_count;
   } track_rsp_type;

   // table predictor and queue of pending responses
   class track_scoreboard;
      logic [10:0] radius;
      logic [15:0] max_age;
      logic [22:0] area_px;
      logic [127:0] stat_classes;
      bit          valid_q[TABLE_ENTRIES];
      logic [6:0]  cls_q[TABLE_ENTRIES];
      logic [10:0] x_q[TABLE_ENTRIES];
      logic [10:0] y_q[TABLE_ENTRIES];
      logic [7:0]  depth_q[TABLE_ENTRIES];
      logic        stat_q[TABLE_ENTRIES];
      logic [31:0] seen_at_q[TABLE_ENTRIES];
      logic [15:0] count_q[TABLE_ENTRIES];
      logic [7:0]  avg_q[TABLE_ENTRIES];
      logic [31:0] now_sec;
      track_rsp_type pending[$];
      int          errors;

      function new();
         radius = 50;
         max_age = 60;
         area_px = 921600;
         stat_classes = {64'd0, 64'd1657324662872358400};
         now_sec = 0;
         errors = 0;
         foreach (valid_q[i]) valid_q[i] = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] data);
         case (idx)
            CSR_MATCH_RADIUS: radius = data[10:0];
            CSR_MAX_AGE:      max_age = data[15:0];
            CSR_FRAME_AREA:   area_px = data[22:0];
            CSR_STAT_LO:      stat_classes[63:0] = data;
            CSR_STAT_HI:      stat_classes[127:64] = data;
            default: ;
         endcase
      endfunction

      function bit near(int i, track_req_type r);
         longint dx, dy;
         if (!valid_q[i] || cls_q[i] != r.class_id) return 0;
         dx = longint'(x_q[i]) - longint'(r.pos_x);
         dy = longint'(y_q[i]) - longint'(r.pos_y);
         return dx * dx + dy * dy < longint'(radius) * longint'(radius);
      endfunction

      function logic [7:0] depth_est(logic [10:0] w, logic [10:0] h);
         longint unsigned fa, d;
         fa = (area_px == 0) ? 1 : area_px;
         d = (longint'(w) * longint'(h) * 2560) / fa;
         return (d > 255) ? 8'd255 : d[7:0];
      endfunction

      function int occupancy();
         int n;
         n = 0;
         foreach (valid_q[i]) n += valid_q[i];
         return n;
      endfunction

      function void note_request(track_req_type r);
         track_rsp_type e;
         int hit;
         longint unsigned n;
         logic [31:0] age;
         e = '{default: '0};
         hit = -1;
         case (r.kind)
            KIND_DETECT: begin
               for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
                  if (near(i, r)) hit = i;
               if (hit >= 0) begin
                  n = count_q[hit];
                  if (n < 65535) n++;
                  x_q[hit] = r.pos_x;
                  y_q[hit] = r.pos_y;
                  stat_q[hit] = r.hint;
                  seen_at_q[hit] = now_sec;
                  count_q[hit] = 16'(n);
                  avg_q[hit] = 8'((longint'(avg_q[hit]) * (n - 1) + r.confidence + n / 2) / n);
                  depth_q[hit] = depth_est(r.box_w, r.box_h);
                  e.status = STATUS_UPDATED;
               end else begin
                  if (occupancy() >= TABLE_ENTRIES)
                     foreach (valid_q[i]) begin
                        age = now_sec - seen_at_q[i];
                        if (valid_q[i] && age >= max_age) begin
                           valid_q[i] = 0;
                           e.removed_count++;
                        end
                     end
                  for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
                     if (!valid_q[i]) hit = i;
                  if (hit >= 0) begin
                     valid_q[hit] = 1;
                     cls_q[hit] = r.class_id;
                     x_q[hit] = r.pos_x;
                     y_q[hit] = r.pos_y;
                     depth_q[hit] = depth_est(r.box_w, r.box_h);
                     stat_q[hit] = r.hint | stat_classes[r.class_id];
                     seen_at_q[hit] = now_sec;
                     count_q[hit] = 1;
                     avg_q[hit] = r.confidence;
                     e.status = STATUS_ADDED;
                  end else begin
                     e.status = STATUS_DROPPED;
                  end
               end
               if (hit >= 0) begin
                  e.slot = 4'(hit);
                  e.seen_count = count_q[hit];
                  e.avg_confidence = avg_q[hit];
                  e.depth = depth_q[hit];
                  e.stationary = stat_q[hit];
               end
            end
            KIND_REMOVE: begin
               foreach (valid_q[i])
                  if (near(i, r)) begin
                     valid_q[i] = 0;
                     e.removed_count++;
                  end
               e.status = STATUS_REMOVED;
            end
            KIND_TICK: begin
               now_sec++;
               e.status = STATUS_TICKED;
            end
            default: begin
               foreach (valid_q[i]) valid_q[i] = 0;
               e.status = STATUS_CLEARED;
            end
         endcase
         e.entry_count = 5'(occupancy());
         pending = {pending, e};
      endfunction

      function void check_response(track_rsp_type a);
         track_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing pending, status %0d", $time, a.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            errors++;
            $display("%0t: mismatch expected st=%0d slot=%0d cnt=%0d avg=%0d dep=%0d stat=%0d rm=%0d n=%0d",
                     $time, e.status, e.slot, e.seen_count, e.avg_confidence, e.depth,
                     e.stationary, e.removed_count, e.entry_count);
            $display("%0t:          actual   st=%0d slot=%0d cnt=%0d avg=%0d dep=%0d stat=%0d rm=%0d n=%0d",
                     $time, a.status, a.slot, a.seen_count, a.avg_confidence, a.depth,
                     a.stationary, a.removed_count, a.entry_count);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [6:0]  req_class_id = '0;
   logic [10:0] req_pos_x = '0;
   logic [10:0] req_pos_y = '0;
   logic [10:0] req_box_w = '0;
   logic [10:0] req_box_h = '0;
   logic [7:0]  req_confidence = '0;
   logic        req_stationary_hint = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot;
   logic [15:0] rsp_seen_count;
   logic [7:0]  rsp_avg_confidence;
   logic [7:0]  rsp_depth;
   logic        rsp_stationary;
   logic [4:0]  rsp_removed_count;
   logic [4:0]  rsp_entry_count;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   track_scoreboard tracker = new();
   int  idle_cycles = 0;
   bit  stall_on = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   detection_track_table i_dut (.*);

   // response check and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response('{rsp_status, rsp_slot, rsp_seen_count, rsp_avg_confidence,
                                  rsp_depth, rsp_stationary, rsp_removed_count,
                                  rsp_entry_count});
      rsp_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_detection_track_table: done, errors");
         $finish;
      end
   end

   task automatic send_request(track_req_type r);
      req_valid <= 1;
      req_kind <= r.kind;
      req_class_id <= r.class_id;
      req_pos_x <= r.pos_x;
      req_pos_y <= r.pos_y;
      req_box_w <= r.box_w;
      req_box_h <= r.box_h;
      req_confidence <= r.confidence;
      req_stationary_hint <= r.hint;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(r);
   endtask

   // burst of requests followed by a random gap
   int burst_left = 0;
   task automatic send_paced(track_req_type r);
      send_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 8);
      end
   endtask

   // csr_valid stays high across back-to-back writes; the caller drops it
   task automatic write_reg(logic [2:0] idx, logic [63:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic track_req_type make_req(logic [1:0] kind, logic [6:0] cls, logic [10:0] x,
                                              logic [10:0] y, logic [10:0] w, logic [10:0] h,
                                              logic [7:0] conf, logic hint);
      track_req_type r;
      r = '{kind, cls, x, y, w, h, conf, hint};
      return r;
   endfunction

   // random request; detections cluster on few classes and spots so they match
   function automatic track_req_type random_req();
      track_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.kind = (pick < 80) ? KIND_DETECT : (pick < 88) ? KIND_REMOVE :
               (pick < 98) ? KIND_TICK : KIND_CLEAR;
      r.class_id = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) begin
         r.pos_x = 11'($urandom);
         r.pos_y = 11'($urandom);
      end else begin
         r.pos_x = 11'(100 * $urandom_range(0, 6) + $urandom_range(0, 40));
         r.pos_y = 11'(1900 + $urandom_range(0, 40));
      end
      r.box_w = 11'($urandom);
      r.box_h = ($urandom_range(0, 1)) ? 11'($urandom) : 11'($urandom_range(0, 300));
      r.confidence = 8'($urandom);
      r.hint = 1'($urandom);
      return r;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: add, update, extremes, remove, full table, eviction sweep with drops, clear
      send_request(make_req(KIND_DETECT, 7'd9, 11'd0, 11'd0, 11'd0, 11'd0, 8'd0, 0));
      send_request(make_req(KIND_DETECT, 7'd9, 11'd10, 11'd10, 11'd2047, 11'd2047, 8'd255, 1));
      send_request(make_req(KIND_DETECT, 7'd127, 11'd2047, 11'd2047, 11'd40, 11'd30, 8'd128, 0));
      send_request(make_req(KIND_DETECT, 7'd127, 11'd2047, 11'd1998, 11'd40, 11'd30, 8'd1, 1));
      send_request(make_req(KIND_REMOVE, 7'd9, 11'd5, 11'd5, 11'd0, 11'd0, 8'd0, 0));
      send_request(make_req(KIND_TICK, 7'd0, 11'd0, 11'd0, 11'd0, 11'd0, 8'd0, 0));
      for (int i = 0; i < 17; i++)
         send_request(make_req(KIND_DETECT, 7'(64 + i), 11'(100 * i), 11'd7, 11'd3, 11'd3,
                               8'd200, 0));
      send_request(make_req(KIND_CLEAR, 7'd0, 11'd0, 11'd0, 11'd0, 11'd0, 8'd0, 0));
      drain();

      // random phases over register settings, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_MATCH_RADIUS, 64'd0);
               write_reg(CSR_MAX_AGE, 64'd0);
               write_reg(CSR_FRAME_AREA, 64'd0);
            end
            1: begin
               write_reg(CSR_MATCH_RADIUS, 64'd2047);
               write_reg(CSR_MAX_AGE, 64'd65535);
               write_reg(CSR_FRAME_AREA, 64'd4194304);
               write_reg(CSR_STAT_LO, '1);
               write_reg(CSR_STAT_HI, '1);
            end
            2: begin
               write_reg(CSR_MATCH_RADIUS, 64'd1);
               write_reg(CSR_FRAME_AREA, 64'd1);
               write_reg(CSR_STAT_LO, '0);
               write_reg(CSR_STAT_HI, '0);
            end
            default: begin
               write_reg(CSR_MATCH_RADIUS, 64'($urandom_range(20, 120)));
               write_reg(CSR_MAX_AGE, 64'($urandom_range(0, 4)));
               write_reg(CSR_FRAME_AREA, 64'($urandom));
               write_reg(CSR_STAT_LO, {$urandom, $urandom});
               write_reg(CSR_STAT_HI, {$urandom, $urandom});
            end
         endcase
         csr_valid <= 0;
         for (int n = 0; n < 235; n++)
            send_paced(random_req());
         drain();
      end

      if (tracker.errors == 0 && tracker.pending.size() == 0)
         $display("tb_detection_track_table: done, clean");
      else
         $display("tb_detection_track_table: done, errors");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/dtt_pkg.sv
sv/dtt_div.sv
sv/detection_track_table.sv
tb/tb_detection_track_table.sv
